>>> hw/rtl/cbq_pkg.sv
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, widths and constants for the cascaded biquad low-pass filter.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int SECTIONS    = 2;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_W      = 32;
  localparam int FRAC_BITS   = 30;
  localparam int PROD_W      = COEF_W + SAMPLE_BITS;
  // five products plus the rounding bias need three guard bits
  localparam int ACC_W       = PROD_W + 3;
  localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CFG_IDX_W   = 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [SEC_W-1:0]              sec_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = CFG_IDX_W'(0),
    REG_B1 = CFG_IDX_W'(1),
    REG_A1 = CFG_IDX_W'(2),
    REG_A2 = CFG_IDX_W'(3)
  } cbq_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_LAST,
    ST_ROUND,
    ST_DONE
  } cbq_state_t;

  typedef enum logic [2:0] {
    TAP_X0,
    TAP_X1,
    TAP_X2,
    TAP_Y1,
    TAP_Y2
  } cbq_tap_t;

  typedef struct packed {
    logic start;
    logic mul_en;
    logic acc_en;
    logic sub;
  } cbq_mac_ctl_t;

  localparam coef_t B0_RESET = 32'sd15181000;
  localparam coef_t B1_RESET = 32'sd30362000;
  localparam coef_t A1_RESET = -32'sd1757297000;
  localparam coef_t A2_RESET = 32'sd744274000;

  localparam acc_t ROUND_BIAS = acc_t'(1) <<< (FRAC_BITS - 1);

endpackage

>>> hw/rtl/cbq_if.sv
// ----------------------------------------------------------------------------
// cbq_if
// Valid/ready channels of the biquad filter: sample in, sample out, config.
// ----------------------------------------------------------------------------
interface cbq_in_if;
  import cbq_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cbq_out_if;
  import cbq_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface cbq_cfg_if;
  import cbq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/cbq_mac.sv
// ----------------------------------------------------------------------------
// cbq_mac
// Shared multiply-accumulate unit: registered 32x16 product, then a
// full-width add or subtract into the accumulator.
// ----------------------------------------------------------------------------
module cbq_mac (
  input  logic                 clk,
  input  cbq_pkg::cbq_mac_ctl_t ctl,
  input  cbq_pkg::coef_t       coef,
  input  cbq_pkg::sample_t     samp,
  output cbq_pkg::acc_t        acc
);
  import cbq_pkg::*;

  prod_t prod_r;
  logic  sub_r;
  acc_t  acc_r;
  acc_t  acc_nxt;
  acc_t  prod_ext;

  assign prod_ext = acc_t'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.start) begin
      acc_nxt = ROUND_BIAS;
    end else if (ctl.acc_en) begin
      acc_nxt = sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coef * samp;
      sub_r  <= ctl.sub;
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

>>> hw/rtl/cascaded_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_lowpass
// Cascade of direct-form-I biquad sections sharing one multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   in_sample  : valid/ready sink, one signed 16-bit sample per transaction.
//   out_sample : valid/ready source, one filtered sample per input sample.
//   cfg_wr     : valid/ready sink, always ready; index 0..3 selects b0, b1,
//                a1, a2 (signed Q2.30), other indexes are ignored. Write only
//                while the filter is idle.
//   Each section runs in steps: five products through the single 32x16
//   multiplier, a drain of the product register into the accumulator, then
//   rounding, saturation and the update of the delay line. A sample is
//   accepted only in the idle state, so a new sample is not taken until
//   the previous one has passed through every section and its result has
//   been loaded into the output register.
//   A finished result waits in the output register; a new sample may be
//   accepted while it waits, but its result is held back until the previous
//   one has been taken.
//   Synchronous reset clears all delay lines, loads the Butterworth 330 Hz /
//   8 kHz coefficients and drops any pending output.
// ----------------------------------------------------------------------------
module cascaded_biquad_lowpass (
  input  logic      clk,
  input  logic      rst_n,
  cbq_in_if.sink    in_sample,
  cbq_out_if.source out_sample,
  cbq_cfg_if.sink   cfg_wr
);
  import cbq_pkg::*;

  cbq_state_t   state_r, state_nxt;
  cbq_tap_t     tap_r, tap_nxt;
  sec_idx_t     sec_r, sec_nxt;
  cbq_mac_ctl_t mac_ctl;

  coef_t b0_r, b1_r, a1_r, a2_r;

  sample_t x1_r [SECTIONS];
  sample_t x2_r [SECTIONS];
  sample_t y1_r [SECTIONS];
  sample_t y2_r [SECTIONS];

  sample_t x_r;
  sample_t out_data_r;
  logic    out_valid_r;

  logic    sec_last;
  logic    upd_delay;
  logic    load_out;
  coef_t   mul_coef;
  sample_t mul_samp;
  acc_t    acc;
  sample_t sat_val;
  logic    fits;

  localparam int TOP_LSB = FRAC_BITS + SAMPLE_BITS - 1;

  assign sec_last = (sec_r == SEC_W'(SECTIONS - 1));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_sample.valid) state_nxt = ST_MAC;
      ST_MAC:   if (tap_r == TAP_Y2) state_nxt = ST_LAST;
      ST_LAST:  state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = sec_last ? ST_DONE : ST_MAC;
      ST_DONE:  if (!out_valid_r || out_sample.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  always_comb begin
    in_sample.ready = 1'b0;
    mac_ctl         = '0;
    upd_delay       = 1'b0;
    load_out        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_sample.ready = 1'b1;
      end
      ST_MAC: begin
        mac_ctl.start  = (tap_r == TAP_X0);
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = (tap_r != TAP_X0);
        mac_ctl.sub    = (tap_r == TAP_Y1) || (tap_r == TAP_Y2);
      end
      ST_LAST: begin
        mac_ctl.acc_en = 1'b1;
      end
      ST_ROUND: begin
        upd_delay = 1'b1;
      end
      ST_DONE: begin
        load_out = !out_valid_r || out_sample.ready;
      end
      default: begin
        in_sample.ready = 1'b0;
      end
    endcase
  end

  // tap and section counters
  always_comb begin
    tap_nxt = TAP_X0;
    if (state_r == ST_MAC && tap_r != TAP_Y2) begin
      tap_nxt = cbq_tap_t'(tap_r + 3'd1);
    end
    sec_nxt = sec_r;
    if (state_r == ST_IDLE) begin
      sec_nxt = '0;
    end else if (upd_delay && !sec_last) begin
      sec_nxt = sec_r + SEC_W'(1);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (tap_r)
      TAP_X0: begin mul_coef = b0_r; mul_samp = x_r;         end
      TAP_X1: begin mul_coef = b1_r; mul_samp = x1_r[sec_r]; end
      TAP_X2: begin mul_coef = b0_r; mul_samp = x2_r[sec_r]; end
      TAP_Y1: begin mul_coef = a1_r; mul_samp = y1_r[sec_r]; end
      TAP_Y2: begin mul_coef = a2_r; mul_samp = y2_r[sec_r]; end
      default: begin mul_coef = b0_r; mul_samp = x_r;        end
    endcase
  end

  cbq_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (mul_coef),
    .samp (mul_samp),
    .acc  (acc)
  );

  // round (bias already in the accumulator), shift down and clamp
  always_comb begin
    fits = (&acc[ACC_W-1:TOP_LSB]) || !(|acc[ACC_W-1:TOP_LSB]);
    if (fits) begin
      sat_val = acc[TOP_LSB:FRAC_BITS];
    end else if (acc[ACC_W-1]) begin
      sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign cfg_wr.ready = 1'b1;

  // ------------------------------------------------------- control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= TAP_X0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
      b0_r        <= B0_RESET;
      b1_r        <= B1_RESET;
      a1_r        <= A1_RESET;
      a2_r        <= A2_RESET;
      for (int s = 0; s < SECTIONS; s++) begin
        x1_r[s] <= '0;
        x2_r[s] <= '0;
        y1_r[s] <= '0;
        y2_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      sec_r   <= sec_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_sample.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr.valid) begin
        case (cbq_reg_t'(cfg_wr.index))
          REG_B0:  b0_r <= coef_t'(cfg_wr.data);
          REG_B1:  b1_r <= coef_t'(cfg_wr.data);
          REG_A1:  a1_r <= coef_t'(cfg_wr.data);
          REG_A2:  a2_r <= coef_t'(cfg_wr.data);
          default: ;
        endcase
      end
      if (upd_delay) begin
        x2_r[sec_r] <= x1_r[sec_r];
        x1_r[sec_r] <= x_r;
        y2_r[sec_r] <= y1_r[sec_r];
        y1_r[sec_r] <= sat_val;
      end
    end
  end

  // --------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (in_sample.valid && in_sample.ready) begin
      x_r <= in_sample.sample_in;
    end else if (upd_delay) begin
      // section output becomes the next section's input
      x_r <= sat_val;
    end
    if (load_out) begin
      out_data_r <= x_r;
    end
  end

  assign out_sample.valid      = out_valid_r;
  assign out_sample.sample_out = out_data_r;

endmodule
